FILE: src/mmlg_pkg.sv
`default_nettype none
package mmlg_pkg;

  localparam int NUM_CATEGORIES = 4;
  localparam int NUM_OUTCOMES   = 4;
  localparam int LANES          = 4;

  localparam int PT_W    = 16;
  localparam int LP_W    = 17;
  localparam int EXP_W   = 56;
  localparam int DEN_W   = 59;
  localparam int SHARE_W = 21;
  localparam int LN_W    = 26;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;
  localparam int LOG_W   = 32;
  localparam int SLOPE_W = 24;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ETA_A  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_ETA_B  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_ETA_C  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_ETA_D  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_OBS    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ACTIVE = 3'd5;

  localparam logic [34:0] LN2_Q30      = 35'd744261118;
  localparam logic [34:0] HALF_LN2_Q30 = 35'd372130559;
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;
  localparam logic [EXP_W-1:0] EXP_CAP = {EXP_W{1'b1}};

  typedef struct packed {
    logic signed [PT_W-1:0] point_e0;
    logic signed [PT_W-1:0] point_e1;
    logic signed [PT_W-1:0] point_e2;
    logic signed [PT_W-1:0] point_e3;
  } point_t;

  typedef struct packed {
    logic signed [LOG_W-1:0]   log_value;
    logic signed [SLOPE_W-1:0] slope_e0;
    logic signed [SLOPE_W-1:0] slope_e1;
    logic signed [SLOPE_W-1:0] slope_e2;
    logic signed [SLOPE_W-1:0] slope_e3;
    logic                      bad_category;
  } result_t;

  typedef struct packed {
    logic exp_go;
    logic div_go;
  } lane_ctl_t;

  typedef struct packed {
    logic exp_done;
    logic div_done;
  } lane_sts_t;

  // eight quotient bits of a division by a small divisor, remainder carried
  function automatic logic [12:0] div8_step(input logic [4:0] rem_in,
                                            input logic [7:0] din,
                                            input logic [4:0] dvs);
    logic [5:0] r;
    logic [7:0] qo;
    r  = {1'b0, rem_in};
    qo = '0;
    for (int b = 7; b >= 0; b--) begin
      r = {r[4:0], din[b]};
      if (r >= {1'b0, dvs}) begin
        r     = r - {1'b0, dvs};
        qo[b] = 1'b1;
      end
    end
    return {r[4:0], qo};
  endfunction

endpackage
`default_nettype wire

FILE: src/mmlg_lane.sv
`default_nettype none
module mmlg_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  mmlg_pkg::lane_ctl_t               ctl,
  input  logic signed [mmlg_pkg::LP_W-1:0]  x,
  input  logic [mmlg_pkg::DEN_W-1:0]        den,
  output mmlg_pkg::lane_sts_t               sts,
  output logic [mmlg_pkg::EXP_W-1:0]        e,
  output logic [mmlg_pkg::SHARE_W-1:0]      share
);
  import mmlg_pkg::*;

  localparam logic [2:0] L_IDLE  = 3'd0;
  localparam logic [2:0] L_RED   = 3'd1;
  localparam logic [2:0] L_FIX   = 3'd2;
  localparam logic [2:0] L_MUL   = 3'd3;
  localparam logic [2:0] L_DIV   = 3'd4;
  localparam logic [2:0] L_SHIFT = 3'd5;
  localparam logic [2:0] L_SDIV  = 3'd6;

  logic [2:0]        state;
  logic              t_neg;
  logic [34:0]       tmag;
  logic [4:0]        q;
  logic [4:0]        cnt;
  logic [31:0]       p;
  logic signed [30:0] r;
  logic signed [6:0] sh;
  logic [3:0]        kd;
  logic              m_neg;
  logic [31:0]       mag;
  logic [4:0]        drem;
  logic [31:0]       quot;
  logic [59:0]       rr;
  logic [20:0]       dq;

  logic signed [35:0] t_full;
  logic [35:0]        t_abs;
  logic [34:0]        red_dvs;
  logic               red_ge;
  logic               frac_nz;
  logic [6:0]         n_mag;
  logic [6:0]         n_val;
  logic [29:0]        fm;
  logic signed [30:0] r_next;
  logic signed [63:0] prod;
  logic [63:0]        prod_abs;
  logic [12:0]        dstep;
  logic [31:0]        quot_n;
  logic [31:0]        p_upd;
  logic [63:0]        sh_wide;
  logic [6:0]         neg_sh;
  logic [EXP_W-1:0]   e_next;
  logic [59:0]        rr2;
  logic               sge;
  logic [59:0]        rr_n;
  logic [20:0]        dq_n;

  always_comb begin
    t_full  = (36'(x) <<< 18) + 36'(HALF_LN2_Q30);
    t_abs   = t_full[35] ? (36'd0 - t_full) : t_full;
    red_dvs = LN2_Q30 << cnt;
    red_ge  = (tmag >= red_dvs);

    // floor division: a negative value with a remainder rounds one further down
    frac_nz = t_neg && (tmag != 35'd0);
    n_mag   = 7'(q) + 7'(frac_nz);
    n_val   = t_neg ? (7'd0 - n_mag) : n_mag;
    fm      = frac_nz ? (LN2_Q30[29:0] - tmag[29:0]) : tmag[29:0];
    r_next  = 31'({1'b0, fm}) - 31'(HALF_LN2_Q30);

    prod     = $signed({1'b0, p}) * r;
    prod_abs = prod[63] ? (64'd0 - prod) : prod;

    dstep  = div8_step(drem, mag[8*cnt[1:0] +: 8], {1'b0, kd});
    quot_n = {quot[23:0], dstep[7:0]};
    p_upd  = m_neg ? (ONE_Q30 - quot_n) : (ONE_Q30 + quot_n);

    sh_wide = '0;
    neg_sh  = 7'd0 - sh;
    if (!sh[6]) begin
      if (sh > 7'sd30) begin
        e_next = EXP_CAP;
      end else begin
        sh_wide = {32'd0, p} << sh[4:0];
        e_next  = (sh_wide > 64'(EXP_CAP)) ? EXP_CAP : sh_wide[EXP_W-1:0];
      end
    end else begin
      if (neg_sh > 7'd62) begin
        e_next = '0;
      end else begin
        sh_wide = ({32'd0, p} + (64'd1 << (neg_sh[5:0] - 6'd1))) >> neg_sh[5:0];
        e_next  = sh_wide[EXP_W-1:0];
      end
    end

    rr2  = {rr[58:0], 1'b0};
    sge  = (rr2 >= {1'b0, den});
    rr_n = sge ? (rr2 - {1'b0, den}) : rr2;
    dq_n = {dq[19:0], sge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      sts   <= '0;
    end else begin
      sts <= '0;
      case (state)
        L_IDLE: begin
          if (ctl.exp_go) begin
            t_neg <= t_full[35];
            tmag  <= t_abs[34:0];
            q     <= '0;
            cnt   <= 5'd4;
            state <= L_RED;
          end else if (ctl.div_go) begin
            rr    <= 60'(e);
            dq    <= '0;
            cnt   <= 5'd20;
            state <= L_SDIV;
          end
        end
        L_RED: begin
          if (red_ge) tmag <= tmag - red_dvs;
          q <= {q[3:0], red_ge};
          if (cnt == 5'd0) state <= L_FIX;
          else cnt <= cnt - 5'd1;
        end
        L_FIX: begin
          r     <= r_next;
          sh    <= n_val + 7'd2;
          p     <= ONE_Q30;
          kd    <= 4'd10;
          state <= L_MUL;
        end
        L_MUL: begin
          mag   <= prod_abs[61:30];
          m_neg <= prod[63];
          drem  <= '0;
          quot  <= '0;
          cnt   <= 5'd3;
          state <= L_DIV;
        end
        L_DIV: begin
          drem <= dstep[12:8];
          quot <= quot_n;
          if (cnt == 5'd0) begin
            p  <= p_upd;
            kd <= kd - 4'd1;
            state <= (kd == 4'd1) ? L_SHIFT : L_MUL;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        L_SHIFT: begin
          e            <= e_next;
          sts.exp_done <= 1'b1;
          state        <= L_IDLE;
        end
        L_SDIV: begin
          rr <= rr_n;
          dq <= dq_n;
          if (cnt == 5'd0) begin
            share        <= 21'((22'(dq_n) + 22'd1) >> 1);
            sts.div_done <= 1'b1;
            state        <= L_IDLE;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/mmlg_ln.sv
`default_nettype none
module mmlg_ln (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [mmlg_pkg::DEN_W-1:0]   d,
  output logic                         done,
  output logic [mmlg_pkg::LN_W-1:0]    ln
);
  import mmlg_pkg::*;

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_NORM = 3'd1;
  localparam logic [2:0] N_SDIV = 3'd2;
  localparam logic [2:0] N_SQ   = 3'd3;
  localparam logic [2:0] N_MUL  = 3'd4;
  localparam logic [2:0] N_DIV  = 3'd5;
  localparam logic [2:0] N_FIN  = 3'd6;

  logic [2:0]  state;
  logic [58:0] v;
  logic [5:0]  pos;
  logic [62:0] rr;
  logic [61:0] dd;
  logic [31:0] s;
  logic [31:0] s2;
  logic [31:0] term;
  logic [33:0] sum;
  logic [3:0]  j;
  logic [4:0]  cnt;
  logic [4:0]  drem;
  logic [31:0] quot;

  logic [62:0] r2;
  logic        ge;
  logic [62:0] rr_n;
  logic [63:0] sq;
  logic [63:0] tp;
  logic [12:0] dstep;
  logic [31:0] quot_n;
  logic [37:0] ln32;

  always_comb begin
    r2     = {rr[61:0], 1'b0};
    ge     = (r2 >= {1'b0, dd});
    rr_n   = ge ? (r2 - {1'b0, dd}) : r2;
    sq     = (64'(s) * 64'(s)) + 64'h8000_0000;
    tp     = (64'(term) * 64'(s2)) + 64'h8000_0000;
    dstep  = div8_step(drem, term[8*cnt[1:0] +: 8], {j, 1'b1});
    quot_n = {quot[23:0], dstep[7:0]};
    ln32   = (38'(pos - 6'd32) * 38'(LN2_Q32)) + {3'd0, sum, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (go) begin
            v     <= d;
            pos   <= 6'd58;
            state <= N_NORM;
          end
        end
        N_NORM: begin
          // mantissa in [1,2): s = (f-1)/(f+1)
          if (v[58]) begin
            rr    <= {3'd0, v[57:0], 2'b00};
            dd    <= {2'b10, v[57:0], 2'b00};
            s     <= '0;
            cnt   <= 5'd31;
            state <= N_SDIV;
          end else begin
            v   <= {v[57:0], 1'b0};
            pos <= pos - 6'd1;
          end
        end
        N_SDIV: begin
          rr <= rr_n;
          s  <= {s[30:0], ge};
          if (cnt == 5'd0) state <= N_SQ;
          else cnt <= cnt - 5'd1;
        end
        N_SQ: begin
          s2    <= sq[63:32];
          term  <= s;
          sum   <= 34'(s);
          j     <= 4'd1;
          state <= N_MUL;
        end
        N_MUL: begin
          term  <= tp[63:32];
          drem  <= '0;
          quot  <= '0;
          cnt   <= 5'd3;
          state <= N_DIV;
        end
        N_DIV: begin
          drem <= dstep[12:8];
          quot <= quot_n;
          if (cnt == 5'd0) begin
            sum <= sum + 34'(quot_n);
            if (j == 4'd12) begin
              state <= N_FIN;
            end else begin
              j     <= j + 4'd1;
              state <= N_MUL;
            end
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        N_FIN: begin
          ln    <= LN_W'((ln32 + 38'd2048) >> 12);
          done  <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/mixed_multinomial_logit_loglik_grad_unit.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------
// request   | start & !busy        | point (point_t)
// result    | done, one cycle      | result (result_t)
// config    | cfg_write            | cfg_index, cfg_data
//
// one outcome runs first in the lane exp units
// (10 horner steps) and then in the shared ln unit
// (normalize search, 32-step divide, 12 series terms)
// an item runs its active outcomes one after another; one request at a time
// synchronous reset returns to idle; done strobes once, the receiver cannot stall
`default_nettype none
module mixed_multinomial_logit_loglik_grad_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  mmlg_pkg::point_t                point,
  output logic                            done,
  output mmlg_pkg::result_t               result,
  input  logic                            cfg_write,
  input  logic [mmlg_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [mmlg_pkg::CFG_W-1:0]      cfg_data
);
  import mmlg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_EXP  = 3'd2;
  localparam logic [2:0] S_DEN  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [LANES-1:0] LANE_USED = LANES'((1 << NUM_CATEGORIES) - 1);

  logic [CFG_W-1:0] eta [4];
  logic [11:0]      obs;
  logic [2:0]       active;

  logic [2:0]        state;
  logic [2:0]        kc;
  logic [2:0]        eff;
  logic              bad;
  logic              exp_go;
  logic              div_go;
  logic [LANES-1:0]  exp_seen;
  logic [LANES-1:0]  div_seen;
  logic              ln_seen;

  logic signed [PT_W-1:0] pt [LANES];
  logic signed [LP_W-1:0] lp [LANES];
  logic [2:0]             cat;
  logic [DEN_W-1:0]       den;
  logic signed [33:0]     logacc;
  logic signed [25:0]     grad [LANES];

  lane_ctl_t              lane_ctl;
  lane_sts_t              lane_sts [LANES];
  logic [EXP_W-1:0]       lane_e [LANES];
  logic [SHARE_W-1:0]     lane_share [LANES];
  logic [LANES-1:0]       exp_done_vec;
  logic [LANES-1:0]       div_done_vec;
  logic                   ln_done;
  logic [LN_W-1:0]        ln_val;

  logic [CFG_W-1:0]       eta_sel;
  logic signed [LP_W-1:0] lp_next [LANES];
  logic [2:0]             cat_raw;
  logic                   cat_bad;
  logic [DEN_W-1:0]       den_next;
  logic signed [LP_W-1:0] lp_obs;
  logic signed [33:0]     logacc_next;
  logic signed [25:0]     grad_next [LANES];
  logic signed [LOG_W-1:0]   log_sat;
  logic signed [SLOPE_W-1:0] slope_sat [LANES];

  assign busy     = (state != S_IDLE);
  assign lane_ctl = '{exp_go: exp_go, div_go: div_go};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) eta[i] <= '0;
      obs    <= '0;
      active <= 3'(NUM_OUTCOMES);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ETA_A:  eta[0] <= cfg_data;
        CFG_ETA_B:  eta[1] <= cfg_data;
        CFG_ETA_C:  eta[2] <= cfg_data;
        CFG_ETA_D:  eta[3] <= cfg_data;
        CFG_OBS:    obs    <= cfg_data[11:0];
        CFG_ACTIVE: active <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < LANES; gi++) begin : g_lane
      if (gi < NUM_CATEGORIES) begin : g_on
        mmlg_lane u_lane (
          .clk   (clk),
          .rst   (rst),
          .ctl   (lane_ctl),
          .x     (lp[gi]),
          .den   (den),
          .sts   (lane_sts[gi]),
          .e     (lane_e[gi]),
          .share (lane_share[gi])
        );
      end else begin : g_off
        assign lane_sts[gi]   = '0;
        assign lane_e[gi]     = '0;
        assign lane_share[gi] = '0;
      end
      assign exp_done_vec[gi] = lane_sts[gi].exp_done;
      assign div_done_vec[gi] = lane_sts[gi].div_done;
    end
  endgenerate

  mmlg_ln u_ln (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .d    (den),
    .done (ln_done),
    .ln   (ln_val)
  );

  // merge: linear predictors, category decode, denominator, log and gradient accumulation, output saturation
  always_comb begin
    eta_sel = eta[kc[1:0]];
    for (int i = 0; i < LANES; i++) begin
      lp_next[i] = LP_W'($signed(eta_sel[16*i +: 16])) + LP_W'(pt[i]);
    end
    cat_raw = obs[4'(kc[1:0]) * 4'd3 +: 3];
    cat_bad = (cat_raw > 3'(NUM_CATEGORIES));

    den_next = DEN_W'(64'h1_0000_0000);
    for (int i = 0; i < LANES; i++) den_next = den_next + DEN_W'(lane_e[i]);

    lp_obs      = lp[2'(cat - 3'd1)];
    logacc_next = logacc - 34'(ln_val) + ((cat != 3'd0) ? (34'(lp_obs) <<< 8) : 34'sd0);
    for (int i = 0; i < LANES; i++) begin
      grad_next[i] = grad[i] - 26'(lane_share[i])
                   + ((cat == 3'(i + 1)) ? 26'sd1048576 : 26'sd0);
    end

    if (logacc > 34'sd2147483647) log_sat = 32'sh7FFF_FFFF;
    else if (logacc < -34'sd2147483648) log_sat = 32'sh8000_0000;
    else log_sat = logacc[31:0];
    for (int i = 0; i < LANES; i++) begin
      if (grad[i] > 26'sd8388607) slope_sat[i] = 24'sh7F_FFFF;
      else if (grad[i] < -26'sd8388608) slope_sat[i] = 24'sh80_0000;
      else slope_sat[i] = grad[i][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      kc       <= '0;
      bad      <= 1'b0;
      done     <= 1'b0;
      exp_go   <= 1'b0;
      div_go   <= 1'b0;
      exp_seen <= '0;
      div_seen <= '0;
      ln_seen  <= 1'b0;
    end else begin
      done   <= 1'b0;
      exp_go <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            kc    <= '0;
            bad   <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (kc >= eff) begin
            state <= S_OUT;
          end else begin
            exp_go   <= 1'b1;
            exp_seen <= ~LANE_USED;
            if (cat_bad) bad <= 1'b1;
            state <= S_EXP;
          end
        end
        S_EXP: begin
          exp_seen <= exp_seen | exp_done_vec;
          if (&(exp_seen | exp_done_vec)) state <= S_DEN;
        end
        S_DEN: begin
          div_go   <= 1'b1;
          div_seen <= ~LANE_USED;
          ln_seen  <= 1'b0;
          state    <= S_DIV;
        end
        S_DIV: begin
          div_seen <= div_seen | div_done_vec;
          ln_seen  <= ln_seen | ln_done;
          if ((&(div_seen | div_done_vec)) && (ln_seen || ln_done)) state <= S_ACC;
        end
        S_ACC: begin
          kc    <= kc + 3'd1;
          state <= S_LOAD;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          pt[0]  <= point.point_e0;
          pt[1]  <= point.point_e1;
          pt[2]  <= point.point_e2;
          pt[3]  <= point.point_e3;
          eff    <= (active > 3'(NUM_OUTCOMES)) ? 3'(NUM_OUTCOMES) : active;
          logacc <= '0;
          for (int i = 0; i < LANES; i++) grad[i] <= '0;
        end
      end
      S_LOAD: begin
        for (int i = 0; i < LANES; i++) lp[i] <= lp_next[i];
        cat <= cat_bad ? 3'd0 : cat_raw;
      end
      S_DEN: den <= den_next;
      S_ACC: begin
        logacc <= logacc_next;
        for (int i = 0; i < LANES; i++) grad[i] <= grad_next[i];
      end
      S_OUT: begin
        result.log_value    <= log_sat;
        result.slope_e0     <= slope_sat[0];
        result.slope_e1     <= slope_sat[1];
        result.slope_e2     <= slope_sat[2];
        result.slope_e3     <= slope_sat[3];
        result.bad_category <= bad;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/mmlg_checker.sv
`default_nettype none
module mmlg_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_stay_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !busy)
    else $error("went busy without a request");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

endmodule

bind mixed_multinomial_logit_loglik_grad_unit mmlg_checker u_mmlg_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire

FILE: dv/tb_mixed_multinomial_logit_loglik_grad_unit.sv
`timescale 1ns / 1ps
module tb_mixed_multinomial_logit_loglik_grad_unit;
  import mmlg_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam longint unsigned EXP_MAX = (64'd1 << 56) - 1;
  localparam longint unsigned UNIT_Q32 = 64'd1 << 32;

  class loglik_scoreboard;
    longint unsigned eta[4];
    logic [11:0] obs_codes;
    logic [2:0] n_active;
    result_t pending[$];
    int errors;
    int checked;
    int flagged;

    function new();
      foreach (eta[i]) eta[i] = '0;
      obs_codes = '0;
      n_active = 3'd4;
      errors = 0;
      checked = 0;
      flagged = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_ETA_A: eta[0] = data;
        CFG_ETA_B: eta[1] = data;
        CFG_ETA_C: eta[2] = data;
        CFG_ETA_D: eta[3] = data;
        CFG_OBS: obs_codes = data[11:0];
        CFG_ACTIVE: n_active = data[2:0];
        default: ;
      endcase
    endfunction

    // exp of a Q.12 value as unsigned Q.32
    function automatic longint unsigned exp_q32(int x);
      longint ln2, xq, t, n, r, p, sh, s;
      longint unsigned e;
      ln2 = longint'(LN2_Q30);
      xq = longint'(x) * 262144;
      t = xq + longint'(HALF_LN2_Q30);
      n = t / ln2;
      if (t % ln2 < 0) n--;
      r = xq - n * ln2;
      p = longint'(ONE_Q30);
      for (int k = 10; k >= 1; k--) p = longint'(ONE_Q30) + (p * r) / (k * longint'(ONE_Q30));
      if (p < 0) p = 0;
      sh = n + 2;
      if (sh >= 0) begin
        if (sh > 30) return EXP_MAX;
        e = longint'(p) << sh;
      end else begin
        s = -sh;
        if (s > 62) return 0;
        e = (longint'(p) + (64'd1 << (s - 1))) >> s;
      end
      return (e > EXP_MAX) ? EXP_MAX : e;
    endfunction

    function automatic longint unsigned div_frac(longint unsigned num, longint unsigned den,
                                                 int bits);
      longint unsigned q, r;
      q = 0;
      r = num;
      for (int b = 0; b < bits; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      return q;
    endfunction

    // natural log of a Q.32 value, Q.20 out
    function automatic longint unsigned ln_q20(longint unsigned v);
      int msb;
      longint unsigned mq, num, den, s, s2, term, acc, ln32;
      if (v < UNIT_Q32) return 0;
      msb = 63;
      while (!v[msb]) msb--;
      if (msb > 58) msb = 58;
      mq = (v << (60 - msb)) & ((64'd1 << 61) - 1);
      num = mq - (64'd1 << 60);
      den = mq + (64'd1 << 60);
      s = div_frac(num, den, 32);
      s2 = (s * s + (64'd1 << 31)) >> 32;
      acc = s;
      term = s;
      for (int j = 1; j <= 12; j++) begin
        term = (term * s2 + (64'd1 << 31)) >> 32;
        acc += term / longint'(2 * j + 1);
      end
      ln32 = longint'(msb - 32) * longint'(LN2_Q32) + 2 * acc;
      return (ln32 + 2048) >> 12;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_point(point_t pt);
      int u[4], lp[4];
      longint unsigned ex[4], den, q;
      longint grad[4], logacc;
      int cat, n_eff;
      logic bad;
      result_t exp_res;
      u[0] = pt.point_e0;
      u[1] = pt.point_e1;
      u[2] = pt.point_e2;
      u[3] = pt.point_e3;
      foreach (grad[i]) grad[i] = 0;
      logacc = 0;
      bad = 1'b0;
      n_eff = (n_active > NUM_OUTCOMES) ? NUM_OUTCOMES : n_active;
      for (int k = 0; k < n_eff; k++) begin
        cat = (obs_codes >> (3 * k)) & 7;
        if (cat > NUM_CATEGORIES) begin
          bad = 1'b1;
          cat = 0;
        end
        den = UNIT_Q32;
        for (int i = 0; i < NUM_CATEGORIES; i++) begin
          lp[i] = int'($signed(eta[k][16*i +: 16])) + u[i];
          ex[i] = exp_q32(lp[i]);
          den += ex[i];
        end
        for (int i = 0; i < NUM_CATEGORIES; i++) begin
          q = div_frac(ex[i], den, 21);
          grad[i] -= longint'((q + 1) >> 1);
        end
        logacc -= longint'(ln_q20(den));
        if (cat >= 1) begin
          logacc += longint'(lp[cat-1]) * 256;
          grad[cat-1] += longint'(1) << 20;
        end
      end
      exp_res.log_value = LOG_W'(clamp(logacc, -64'sd2147483648, 64'sd2147483647));
      exp_res.slope_e0 = SLOPE_W'(clamp(grad[0], -8388608, 8388607));
      exp_res.slope_e1 = SLOPE_W'(clamp(grad[1], -8388608, 8388607));
      exp_res.slope_e2 = SLOPE_W'(clamp(grad[2], -8388608, 8388607));
      exp_res.slope_e3 = SLOPE_W'(clamp(grad[3], -8388608, 8388607));
      exp_res.bad_category = bad;
      if (bad) flagged++;
      pending.push_back(exp_res);
    endfunction

    function void cmp_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      cmp_field("log_value", want.log_value, got.log_value);
      cmp_field("slope_e0", want.slope_e0, got.slope_e0);
      cmp_field("slope_e1", want.slope_e1, got.slope_e1);
      cmp_field("slope_e2", want.slope_e2, got.slope_e2);
      cmp_field("slope_e3", want.slope_e3, got.slope_e3);
      cmp_field("bad_category", want.bad_category, got.bad_category);
    endfunction
  endclass

  logic clk, rst, start, busy, done, cfg_write;
  point_t point;
  result_t result;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  loglik_scoreboard sb;
  int quiet_cycles;
  int sent;
  bit allow_idle;

  mixed_multinomial_logit_loglik_grad_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic settle();
    while (sb.pending.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic send_point(point_t p);
    if (allow_idle && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
    start = 1'b1;
    point = p;
    do @(posedge clk); while (busy);
    sb.note_point(p);
    sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic [15:0] rand_q12();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 16383)) - 8192);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_eta();
    return {rand_q12(), rand_q12(), rand_q12(), rand_q12()};
  endfunction

  task automatic random_config();
    settle();
    for (int r = 0; r < 4; r++) write_reg(CIDX_W'(CFG_ETA_A + r), rand_eta());
    // mostly legal codes, sometimes out-of-range ones
    write_reg(CFG_OBS, ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 4095)) :
      64'({3'($urandom_range(0, 4)), 3'($urandom_range(0, 4)),
           3'($urandom_range(0, 4)), 3'($urandom_range(0, 4))}));
    write_reg(CFG_ACTIVE, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7)) :
      64'($urandom_range(1, 4)));
  endtask

  task automatic random_point();
    point_t p;
    p.point_e0 = rand_q12();
    p.point_e1 = rand_q12();
    p.point_e2 = rand_q12();
    p.point_e3 = rand_q12();
    send_point(p);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    point = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    allow_idle = 1'b1;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset configuration, extremes of the point
    send_point('0);
    send_point({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_point({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_point({16'h7fff, 16'h8000, 16'hffff, 16'h0001});

    // every category observed, predictors at the extremes
    settle();
    write_reg(CFG_ETA_A, {4{16'h7fff}});
    write_reg(CFG_ETA_B, {4{16'h8000}});
    write_reg(CFG_ETA_C, 64'hffff_ffff_ffff_ffff);
    write_reg(CFG_ETA_D, 64'h0001_8000_7fff_0000);
    write_reg(CFG_OBS, 64'({3'd4, 3'd3, 3'd2, 3'd1}));
    write_reg(CFG_ACTIVE, 64'd4);
    send_point({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_point({16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_point({16'h1000, 16'hf000, 16'h0800, 16'h0000});

    // category codes above the count
    settle();
    write_reg(CFG_OBS, 64'({3'd7, 3'd6, 3'd5, 3'd0}));
    send_point({16'h0400, 16'hfc00, 16'h2000, 16'he000});
    send_point('0);

    // bad codes only in inactive outcomes, with a single active outcome
    settle();
    write_reg(CFG_OBS, 64'({3'd7, 3'd7, 3'd7, 3'd2}));
    write_reg(CFG_ACTIVE, 64'd1);
    send_point({16'h0400, 16'hfc00, 16'h2000, 16'he000});
    send_point({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});

    // active count of zero and above the limit
    settle();
    write_reg(CFG_ACTIVE, 64'd0);
    send_point({16'h1234, 16'h8000, 16'h7fff, 16'hffff});
    settle();
    write_reg(CFG_ACTIVE, 64'd7);
    write_reg(CFG_OBS, 64'hfff);
    send_point({16'h1234, 16'h8000, 16'h7fff, 16'hffff});
    settle();
    write_reg(CFG_ACTIVE, 64'd5);
    write_reg(CFG_OBS, 64'({3'd1, 3'd4, 3'd0, 3'd3}));
    send_point({16'h0100, 16'h0200, 16'hff00, 16'hfe00});

    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      if (ph == 9) allow_idle = 1'b0;
      repeat (64) random_point();
    end

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("covered %0d requests, %0d results checked, %0d with a bad category code",
             sent, sb.checked, sb.flagged);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
